// ===== design/itch_pkg.sv =====
// Package with the shared types, codes and lookup function of the message parser.
package itch_pkg;

    localparam int OFFSET_BITS = 48;
    localparam logic [47:0] DAY_NS = 48'd86400000000000;

    // Error codes carried on the result.
    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_TYPE      = 4'd1,
        ERR_LENGTH    = 4'd2,
        ERR_TIMESTAMP = 4'd3,
        ERR_EVENT     = 4'd4,
        ERR_SIDE      = 4'd5,
        ERR_PRINTABLE = 4'd6,
        ERR_TEXT      = 4'd7,
        ERR_PREFIX    = 4'd8,
        ERR_PAYLOAD   = 4'd9,
        ERR_AFTER_END = 4'd10
    } t_err;

    // Framing phase of the stream.
    typedef enum logic [1:0] {
        PH_LEN_HI  = 2'd0,
        PH_LEN_LO  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    // Result of the byte decoder for one payload byte.
    typedef struct packed {
        logic        set_err;
        t_err        err;
        logic        ts_err;
        logic        sh_locate;
        logic        sh_tracking;
        logic        sh_ts;
        logic        sh_order;
        logic        sh_second;
        logic        sh_shares;
        logic        sh_price;
        logic        sh_symbol;
        logic        set_detail;
        logic [2:0]  detail;
    } t_dec;

    // Expected payload length per message type; zero marks an unknown type.
    function automatic logic [5:0] expected_length(input logic [7:0] t);
        case (t)
            8'h53: expected_length = 6'd12; // S
            8'h52: expected_length = 6'd39; // R
            8'h41: expected_length = 6'd36; // A
            8'h46: expected_length = 6'd40; // F
            8'h45: expected_length = 6'd31; // E
            8'h43: expected_length = 6'd36; // C
            8'h58: expected_length = 6'd23; // X
            8'h44: expected_length = 6'd19; // D
            8'h55: expected_length = 6'd35; // U
            8'h50: expected_length = 6'd44; // P
            8'h48: expected_length = 6'd25; // H
            8'h59: expected_length = 6'd20; // Y
            8'h4C: expected_length = 6'd26; // L
            8'h56: expected_length = 6'd35; // V
            8'h57: expected_length = 6'd12; // W
            8'h4B: expected_length = 6'd28; // K
            8'h4A: expected_length = 6'd35; // J
            8'h68: expected_length = 6'd21; // h
            8'h51: expected_length = 6'd40; // Q
            8'h42: expected_length = 6'd19; // B
            8'h49: expected_length = 6'd50; // I
            8'h4E: expected_length = 6'd20; // N
            default: expected_length = 6'd0;
        endcase
    endfunction

endpackage

// ===== design/itch_message_parser.sv =====
// Top level of the byte-serial ITCH frame parser with a registered result stage.
//
//  Channel | Direction | Handshake             | Payload
//  in      | input     | i_valid / o_ready     | i_data_byte, i_end_of_stream
//  out     | output    | o_valid / i_ready     | o_message_type ... o_error_offset
//
// One byte is taken per cycle while o_ready is high; each byte updates the frame state.
// A result appears in the output register the cycle after the frame's last byte.
// The input stalls only while a result is held and the output is stalled.
// Synchronous active-low reset clears the framing, offsets and halt flag.
// After an error or end of stream the block takes bytes but gives no result.
module itch_message_parser
    import itch_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_message_type,
    output logic [15:0] o_stock_locate,
    output logic [15:0] o_tracking_number,
    output logic [46:0] o_time_ns,
    output logic [63:0] o_order_ref,
    output logic [63:0] o_second_ref,
    output logic [31:0] o_shares,
    output logic [31:0] o_price,
    output logic [63:0] o_symbol,
    output logic [2:0]  o_detail,
    output logic [3:0]  o_error_code,
    output logic [47:0] o_error_offset
);

    t_phase                 r_phase, n_phase;
    logic [15:0]            r_len, n_len;
    logic [15:0]            r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [OFFSET_BITS-1:0] r_fstart, n_fstart;
    logic [OFFSET_BITS-1:0] r_pstart, n_pstart;
    logic [7:0]             r_type, n_type;
    logic [15:0]            r_loc, n_loc;
    logic [15:0]            r_trk, n_trk;
    logic [47:0]            r_ts, n_ts;
    logic [63:0]            r_ord, n_ord;
    logic [63:0]            r_sec, n_sec;
    logic [31:0]            r_shr, n_shr;
    logic [31:0]            r_prc, n_prc;
    logic [63:0]            r_sym, n_sym;
    logic [2:0]             r_det, n_det;
    t_err                   r_err, n_err;
    logic [OFFSET_BITS-1:0] r_eoff, n_eoff;
    logic                   r_ended, n_ended;
    logic                   r_halt, n_halt;

    logic                   r_ovalid;
    logic                   emit;
    logic [3:0]             e_code;
    logic [47:0]            e_off;
    logic                   e_fail;
    logic                   accept;
    t_dec                   dec;
    logic [5:0]             exp_len;
    logic [47:0]            ts_next;

    assign o_ready = !r_ovalid || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_ovalid;

    itch_field_decode u_dec (
        .i_pos  (r_pos),
        .i_type (r_type),
        .i_byte (i_data_byte),
        .o_dec  (dec)
    );

    assign exp_len = expected_length(i_data_byte);
    assign ts_next = {r_ts[39:0], i_data_byte};

    // Next state of the framing and held fields for one accepted item.
    always_comb begin
        n_phase = r_phase; n_len = r_len; n_pos = r_pos; n_off = r_off;
        n_fstart = r_fstart; n_pstart = r_pstart; n_type = r_type;
        n_loc = r_loc; n_trk = r_trk; n_ts = r_ts; n_ord = r_ord; n_sec = r_sec;
        n_shr = r_shr; n_prc = r_prc; n_sym = r_sym; n_det = r_det;
        n_err = r_err; n_eoff = r_eoff; n_ended = r_ended; n_halt = r_halt;
        emit = 1'b0; e_code = ERR_NONE; e_off = '0; e_fail = 1'b0;
        if (accept && !r_halt) begin
            if (i_end_of_stream) begin
                n_halt = 1'b1;
                if (!r_ended && r_phase != PH_LEN_HI) begin
                    emit = 1'b1; e_fail = 1'b1;
                    e_code = (r_phase == PH_LEN_LO) ? ERR_PREFIX : ERR_PAYLOAD;
                    e_off = 48'(r_fstart);
                end
            end else begin
                n_off = r_off + 1'b1;
                if (r_ended) begin
                    n_halt = 1'b1; emit = 1'b1; e_fail = 1'b1;
                    e_code = ERR_AFTER_END; e_off = 48'(r_off);
                end else if (r_phase == PH_LEN_LO) begin
                    n_len = {r_len[7:0], i_data_byte};
                    if (n_len == 16'd0) begin
                        n_ended = 1'b1; n_phase = PH_LEN_HI;
                    end else begin
                        n_phase = PH_PAYLOAD; n_pos = '0; n_pstart = n_off;
                        n_type = '0; n_loc = '0; n_trk = '0; n_ts = '0; n_ord = '0;
                        n_sec = '0; n_shr = '0; n_prc = '0; n_sym = '0; n_det = '0;
                        n_err = ERR_NONE; n_eoff = '0;
                    end
                end else if (r_phase != PH_PAYLOAD) begin
                    n_phase = PH_LEN_LO; n_fstart = r_off;
                    n_len = {8'd0, i_data_byte};
                end else begin
                    if (r_pos == 16'd0) begin
                        n_type = i_data_byte;
                        if (exp_len == 6'd0) begin
                            n_err = ERR_TYPE; n_eoff = r_off;
                        end else if (r_len != {10'd0, exp_len}) begin
                            n_err = ERR_LENGTH; n_eoff = r_off;
                        end
                        if (i_data_byte == "E") n_det = 3'd1;
                    end else if (r_err == ERR_NONE) begin
                        if (dec.sh_locate)   n_loc = {r_loc[7:0], i_data_byte};
                        if (dec.sh_tracking) n_trk = {r_trk[7:0], i_data_byte};
                        if (dec.sh_ts)       n_ts = ts_next;
                        if (dec.sh_order)    n_ord = {r_ord[55:0], i_data_byte};
                        if (dec.sh_second)   n_sec = {r_sec[55:0], i_data_byte};
                        if (dec.sh_shares)   n_shr = {r_shr[23:0], i_data_byte};
                        if (dec.sh_price)    n_prc = {r_prc[23:0], i_data_byte};
                        if (dec.sh_symbol)   n_sym = {r_sym[55:0], i_data_byte};
                        if (dec.set_detail)  n_det = dec.detail;
                        if (dec.ts_err && ts_next >= DAY_NS) begin
                            n_err = ERR_TIMESTAMP;
                            n_eoff = r_pstart + OFFSET_BITS'(5);
                        end else if (dec.set_err) begin
                            n_err = dec.err; n_eoff = r_off;
                        end
                    end
                    n_pos = r_pos + 1'b1;
                    if (n_pos >= r_len) begin
                        n_phase = PH_LEN_HI; emit = 1'b1;
                        if (n_err != ERR_NONE) begin
                            e_fail = 1'b1; n_halt = 1'b1;
                            e_code = n_err; e_off = 48'(n_eoff);
                        end
                    end
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN_HI; r_len <= '0; r_pos <= '0; r_off <= '0;
            r_fstart <= '0; r_pstart <= '0; r_type <= '0; r_loc <= '0;
            r_trk <= '0; r_ts <= '0; r_ord <= '0; r_sec <= '0; r_shr <= '0;
            r_prc <= '0; r_sym <= '0; r_det <= '0; r_err <= ERR_NONE;
            r_eoff <= '0; r_ended <= 1'b0; r_halt <= 1'b0;
        end else begin
            r_phase <= n_phase; r_len <= n_len; r_pos <= n_pos; r_off <= n_off;
            r_fstart <= n_fstart; r_pstart <= n_pstart; r_type <= n_type;
            r_loc <= n_loc; r_trk <= n_trk; r_ts <= n_ts; r_ord <= n_ord;
            r_sec <= n_sec; r_shr <= n_shr; r_prc <= n_prc; r_sym <= n_sym;
            r_det <= n_det; r_err <= n_err; r_eoff <= n_eoff;
            r_ended <= n_ended; r_halt <= n_halt;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_message_type    <= e_fail ? 8'd0  : n_type;
            o_stock_locate    <= e_fail ? 16'd0 : n_loc;
            o_tracking_number <= e_fail ? 16'd0 : n_trk;
            o_time_ns         <= e_fail ? 47'd0 : n_ts[46:0];
            o_order_ref       <= e_fail ? 64'd0 : n_ord;
            o_second_ref      <= e_fail ? 64'd0 : n_sec;
            o_shares          <= e_fail ? 32'd0 : n_shr;
            o_price           <= e_fail ? 32'd0 : n_prc;
            o_symbol          <= e_fail ? 64'd0 : n_sym;
            o_detail          <= e_fail ? 3'd0  : n_det;
            o_error_code      <= e_code;
            o_error_offset    <= e_off;
        end
    end

    // A halted block never raises a new result.
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> !emit) else $error("result after halt");
    // A clean result carries a zero offset.
    a_ok_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_code == ERR_NONE) |-> (o_error_offset == 48'd0))
        else $error("offset on clean result");
    // Payload position stays below the frame length inside a payload.
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_pos < r_len)) else $error("position overrun");
    // An unaccepted result stays valid.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");

endmodule

// ===== design/itch_field_decode.sv =====
// Combinational decoder that maps one payload byte to field updates and checks.
module itch_field_decode
    import itch_pkg::*;
(
    input  logic [15:0] i_pos,
    input  logic [7:0]  i_type,
    input  logic [7:0]  i_byte,
    output t_dec        o_dec
);

    function automatic logic in_rng(input logic [15:0] p, input int lo, input int n);
        in_rng = (p >= 16'(lo)) && (p < 16'(lo + n));
    endfunction

    logic txt_bad;
    logic is_afp;

    assign txt_bad = (i_byte < 8'd32) || (i_byte > 8'd126);
    assign is_afp  = (i_type == "A") || (i_type == "F") || (i_type == "P");

    // Field routing per message type and payload position.
    always_comb begin
        o_dec = '0;
        o_dec.err = ERR_NONE;
        if (i_pos >= 16'd1 && i_pos <= 16'd2) begin
            o_dec.sh_locate = 1'b1;
        end else if (i_pos >= 16'd3 && i_pos <= 16'd4) begin
            o_dec.sh_tracking = 1'b1;
        end else if (i_pos >= 16'd5 && i_pos <= 16'd10) begin
            o_dec.sh_ts = 1'b1;
            o_dec.ts_err = (i_pos == 16'd10);
        end else if (i_pos > 16'd10) begin
            if (i_type == "S") begin
                if (i_pos == 16'd11) begin
                    o_dec.set_detail = 1'b1;
                    case (i_byte)
                        "O": o_dec.detail = 3'd0;
                        "S": o_dec.detail = 3'd1;
                        "Q": o_dec.detail = 3'd2;
                        "M": o_dec.detail = 3'd3;
                        "E": o_dec.detail = 3'd4;
                        "C": o_dec.detail = 3'd5;
                        default: begin
                            o_dec.set_detail = 1'b0;
                            o_dec.set_err = 1'b1;
                            o_dec.err = ERR_EVENT;
                        end
                    endcase
                end
            end else if (i_type == "R") begin
                if (in_rng(i_pos, 11, 8)) begin
                    o_dec.sh_symbol = 1'b1;
                    o_dec.set_err = txt_bad;
                    o_dec.err = ERR_TEXT;
                end else if (in_rng(i_pos, 21, 4)) begin
                    o_dec.sh_shares = 1'b1;
                end else if (in_rng(i_pos, 27, 2)) begin
                    o_dec.set_err = txt_bad;
                    o_dec.err = ERR_TEXT;
                end
            end else if (is_afp) begin
                if (in_rng(i_pos, 11, 8)) begin
                    o_dec.sh_order = (i_type != "P");
                end else if (i_pos == 16'd19) begin
                    if (i_byte != "B" && i_byte != "S") begin
                        o_dec.set_err = 1'b1;
                        o_dec.err = ERR_SIDE;
                    end else begin
                        o_dec.set_detail = (i_type != "P");
                        o_dec.detail = (i_byte == "B") ? 3'd0 : 3'd1;
                    end
                end else if (in_rng(i_pos, 20, 4)) begin
                    o_dec.sh_shares = 1'b1;
                end else if (in_rng(i_pos, 24, 8)) begin
                    o_dec.sh_symbol = 1'b1;
                    o_dec.set_err = txt_bad;
                    o_dec.err = ERR_TEXT;
                end else if (in_rng(i_pos, 32, 4)) begin
                    o_dec.sh_price = 1'b1;
                end else if (i_type == "F" && in_rng(i_pos, 36, 4)) begin
                    o_dec.set_err = txt_bad;
                    o_dec.err = ERR_TEXT;
                end else if (i_type == "P" && in_rng(i_pos, 36, 8)) begin
                    o_dec.sh_second = 1'b1;
                end
            end else if (i_type == "E" || i_type == "C") begin
                if (in_rng(i_pos, 11, 8)) begin
                    o_dec.sh_order = 1'b1;
                end else if (in_rng(i_pos, 19, 4)) begin
                    o_dec.sh_shares = 1'b1;
                end else if (in_rng(i_pos, 23, 8)) begin
                    o_dec.sh_second = 1'b1;
                end else if (i_type == "C" && i_pos == 16'd31) begin
                    if (i_byte != "Y" && i_byte != "N") begin
                        o_dec.set_err = 1'b1;
                        o_dec.err = ERR_PRINTABLE;
                    end else begin
                        o_dec.set_detail = 1'b1;
                        o_dec.detail = (i_byte == "Y") ? 3'd1 : 3'd0;
                    end
                end else if (i_type == "C" && in_rng(i_pos, 32, 4)) begin
                    o_dec.sh_price = 1'b1;
                end
            end else if (i_type == "X" || i_type == "D") begin
                if (in_rng(i_pos, 11, 8)) begin
                    o_dec.sh_order = 1'b1;
                end else if (i_type == "X" && in_rng(i_pos, 19, 4)) begin
                    o_dec.sh_shares = 1'b1;
                end
            end else if (i_type == "U") begin
                if (in_rng(i_pos, 11, 8)) begin
                    o_dec.sh_order = 1'b1;
                end else if (in_rng(i_pos, 19, 8)) begin
                    o_dec.sh_second = 1'b1;
                end else if (in_rng(i_pos, 27, 4)) begin
                    o_dec.sh_shares = 1'b1;
                end else if (in_rng(i_pos, 31, 4)) begin
                    o_dec.sh_price = 1'b1;
                end
            end
        end
    end

endmodule

// ===== tb/tb_itch_message_parser.sv =====
// Self-checking testbench for the byte-serial ITCH frame parser.
`timescale 1ns / 100ps

module tb_itch_message_parser;
    import itch_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int QUIET_TAIL  = 150;
    localparam logic [47:0] ONE_DAY = 48'd86400000000000;

    // Message type bytes.
    localparam logic [7:0] MT_SYS      = "S";
    localparam logic [7:0] MT_DIR      = "R";
    localparam logic [7:0] MT_ADD      = "A";
    localparam logic [7:0] MT_ADD_ATTR = "F";
    localparam logic [7:0] MT_EXEC     = "E";
    localparam logic [7:0] MT_EXEC_PX  = "C";
    localparam logic [7:0] MT_CANCEL   = "X";
    localparam logic [7:0] MT_DELETE   = "D";
    localparam logic [7:0] MT_REPLACE  = "U";
    localparam logic [7:0] MT_TRADE    = "P";
    localparam logic [7:0] MT_HALT     = "H";
    localparam logic [7:0] MT_REGSHO   = "Y";
    localparam logic [7:0] MT_MPPOS    = "L";
    localparam logic [7:0] MT_MWCB_LVL = "V";
    localparam logic [7:0] MT_MWCB_ST  = "W";
    localparam logic [7:0] MT_IPO      = "K";
    localparam logic [7:0] MT_LULD     = "J";
    localparam logic [7:0] MT_OP_HALT  = "h";
    localparam logic [7:0] MT_CROSS    = "Q";
    localparam logic [7:0] MT_BROKEN   = "B";
    localparam logic [7:0] MT_NOII     = "I";
    localparam logic [7:0] MT_RPII     = "N";

    localparam logic [7:0] TYPE_LIST [22] = '{
        MT_SYS, MT_DIR, MT_ADD, MT_ADD_ATTR, MT_EXEC, MT_EXEC_PX, MT_CANCEL,
        MT_DELETE, MT_REPLACE, MT_TRADE, MT_HALT, MT_REGSHO, MT_MPPOS,
        MT_MWCB_LVL, MT_MWCB_ST, MT_IPO, MT_LULD, MT_OP_HALT, MT_CROSS,
        MT_BROKEN, MT_NOII, MT_RPII
    };

    // Field value codes.
    localparam logic [7:0] EV_CODES [6] = '{"O", "S", "Q", "M", "E", "C"};
    localparam logic [7:0] SIDE_BUY  = "B";
    localparam logic [7:0] SIDE_SELL = "S";
    localparam logic [7:0] PRN_YES   = "Y";
    localparam logic [7:0] PRN_NO    = "N";
    localparam logic [7:0] TXT_LO    = 8'd32;
    localparam logic [7:0] TXT_HI    = 8'd126;

    // Byte fill styles and injected faults for frame generation.
    localparam int FILL_RAND = 0;
    localparam int FILL_ZERO = 1;
    localparam int FILL_ONES = 2;

    localparam int FLT_NONE   = 0;
    localparam int FLT_TYPE   = 1;
    localparam int FLT_LENGTH = 2;
    localparam int FLT_TS     = 3;
    localparam int FLT_EVENT  = 4;
    localparam int FLT_SIDE   = 5;
    localparam int FLT_PRINT  = 6;
    localparam int FLT_TEXT   = 7;

    typedef struct packed {
        logic [7:0]  mtype;
        logic [15:0] locate;
        logic [15:0] tracking;
        logic [46:0] ts;
        logic [63:0] oref;
        logic [63:0] sref;
        logic [31:0] shares;
        logic [31:0] price;
        logic [63:0] symbol;
        logic [2:0]  detail;
        t_err        err;
        logic [47:0] eoff;
    } t_frame_result;

    typedef struct packed {
        logic [7:0] b;
        logic       eos;
        logic       hold;
    } t_stream_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_end_of_stream = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_message_type;
    logic [15:0] o_stock_locate;
    logic [15:0] o_tracking_number;
    logic [46:0] o_time_ns;
    logic [63:0] o_order_ref;
    logic [63:0] o_second_ref;
    logic [31:0] o_shares;
    logic [31:0] o_price;
    logic [63:0] o_symbol;
    logic [2:0]  o_detail;
    logic [3:0]  o_error_code;
    logic [47:0] o_error_offset;

    itch_message_parser u_dut (.*);

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_stream_item  stream_q [$];
    t_frame_result frame_results_q [$];
    int            mismatches = 0;
    int            cycles = 0;

    // Parser shadow state.
    t_phase        sh_phase;
    logic [15:0]   sh_len;
    logic [15:0]   sh_pos;
    logic [47:0]   sh_off;
    logic [47:0]   sh_frame_start;
    logic [47:0]   sh_payload_start;
    t_frame_result sh_held;
    logic [47:0]   sh_ts48;
    t_err          sh_err;
    logic [47:0]   sh_err_off;
    logic          sh_ended;
    logic          sh_halted;

    function automatic int frame_len_for(input logic [7:0] t);
        case (t)
            MT_SYS:      return 12;
            MT_DIR:      return 39;
            MT_ADD:      return 36;
            MT_ADD_ATTR: return 40;
            MT_EXEC:     return 31;
            MT_EXEC_PX:  return 36;
            MT_CANCEL:   return 23;
            MT_DELETE:   return 19;
            MT_REPLACE:  return 35;
            MT_TRADE:    return 44;
            MT_HALT:     return 25;
            MT_REGSHO:   return 20;
            MT_MPPOS:    return 26;
            MT_MWCB_LVL: return 35;
            MT_MWCB_ST:  return 12;
            MT_IPO:      return 28;
            MT_LULD:     return 35;
            MT_OP_HALT:  return 21;
            MT_CROSS:    return 40;
            MT_BROKEN:   return 19;
            MT_NOII:     return 50;
            MT_RPII:     return 20;
            default:     return 0;
        endcase
    endfunction

    function automatic logic in_span(input int p, input int lo, input int n);
        return p >= lo && p < lo + n;
    endfunction

    function automatic logic is_text(input logic [7:0] t, input int p);
        return (t == MT_DIR && (in_span(p, 11, 8) || in_span(p, 27, 2)))
            || ((t == MT_ADD || t == MT_ADD_ATTR || t == MT_TRADE) && in_span(p, 24, 8))
            || (t == MT_ADD_ATTR && in_span(p, 36, 4));
    endfunction

    task automatic clear_shadow_fields();
        sh_held = '0;
        sh_ts48 = '0;
    endtask

    task automatic reset_shadow();
        sh_phase = PH_LEN_HI;
        sh_len = '0;
        sh_pos = '0;
        sh_off = '0;
        sh_frame_start = '0;
        sh_payload_start = '0;
        clear_shadow_fields();
        sh_err = ERR_NONE;
        sh_err_off = '0;
        sh_ended = 1'b0;
        sh_halted = 1'b0;
    endtask

    // Only the first error of a frame is kept.
    task automatic note_error(input t_err code, input logic [47:0] off);
        if (sh_err == ERR_NONE) begin
            sh_err = code;
            sh_err_off = off;
        end
    endtask

    task automatic push_error(input t_err code, input logic [47:0] off);
        t_frame_result r;
        r = '0;
        r.err = code;
        r.eoff = off;
        frame_results_q.push_back(r);
        sh_halted = 1'b1;
    endtask

    task automatic check_text(input logic [7:0] b, input logic [47:0] off);
        if (b < TXT_LO || b > TXT_HI) note_error(ERR_TEXT, off);
    endtask

    // Field extraction and checks for one payload byte.
    task automatic take_payload(input int p, input logic [7:0] b, input logic [47:0] off);
        logic [7:0] t;
        int         el;
        logic       hit;
        t = sh_held.mtype;
        if (p == 0) begin
            sh_held.mtype = b;
            el = frame_len_for(b);
            if (el == 0) note_error(ERR_TYPE, off);
            else if (int'(sh_len) != el) note_error(ERR_LENGTH, off);
            if (b == MT_EXEC) sh_held.detail = 3'd1;
            return;
        end
        if (sh_err != ERR_NONE) return;
        if (p <= 2) begin
            sh_held.locate = {sh_held.locate[7:0], b};
            return;
        end
        if (p <= 4) begin
            sh_held.tracking = {sh_held.tracking[7:0], b};
            return;
        end
        if (p <= 10) begin
            sh_ts48 = {sh_ts48[39:0], b};
            if (p == 10 && sh_ts48 >= ONE_DAY)
                note_error(ERR_TIMESTAMP, sh_payload_start + 48'd5);
            return;
        end
        case (t)
            MT_SYS: begin
                if (p == 11) begin
                    hit = 1'b0;
                    for (int i = 0; i < 6; i++) begin
                        if (b == EV_CODES[i]) begin
                            sh_held.detail = 3'(i);
                            hit = 1'b1;
                        end
                    end
                    if (!hit) note_error(ERR_EVENT, off);
                end
            end
            MT_DIR: begin
                if (in_span(p, 11, 8)) begin
                    sh_held.symbol = {sh_held.symbol[55:0], b};
                    check_text(b, off);
                end else if (in_span(p, 21, 4)) begin
                    sh_held.shares = {sh_held.shares[23:0], b};
                end else if (in_span(p, 27, 2)) begin
                    check_text(b, off);
                end
            end
            MT_ADD, MT_ADD_ATTR, MT_TRADE: begin
                if (in_span(p, 11, 8)) begin
                    if (t != MT_TRADE) sh_held.oref = {sh_held.oref[55:0], b};
                end else if (p == 19) begin
                    if (b != SIDE_BUY && b != SIDE_SELL) note_error(ERR_SIDE, off);
                    else if (t != MT_TRADE) sh_held.detail = (b == SIDE_BUY) ? 3'd0 : 3'd1;
                end else if (in_span(p, 20, 4)) begin
                    sh_held.shares = {sh_held.shares[23:0], b};
                end else if (in_span(p, 24, 8)) begin
                    sh_held.symbol = {sh_held.symbol[55:0], b};
                    check_text(b, off);
                end else if (in_span(p, 32, 4)) begin
                    sh_held.price = {sh_held.price[23:0], b};
                end else if (t == MT_ADD_ATTR && in_span(p, 36, 4)) begin
                    check_text(b, off);
                end else if (t == MT_TRADE && in_span(p, 36, 8)) begin
                    sh_held.sref = {sh_held.sref[55:0], b};
                end
            end
            MT_EXEC, MT_EXEC_PX: begin
                if (in_span(p, 11, 8)) begin
                    sh_held.oref = {sh_held.oref[55:0], b};
                end else if (in_span(p, 19, 4)) begin
                    sh_held.shares = {sh_held.shares[23:0], b};
                end else if (in_span(p, 23, 8)) begin
                    sh_held.sref = {sh_held.sref[55:0], b};
                end else if (t == MT_EXEC_PX && p == 31) begin
                    if (b != PRN_YES && b != PRN_NO) note_error(ERR_PRINTABLE, off);
                    else sh_held.detail = (b == PRN_YES) ? 3'd1 : 3'd0;
                end else if (t == MT_EXEC_PX && in_span(p, 32, 4)) begin
                    sh_held.price = {sh_held.price[23:0], b};
                end
            end
            MT_CANCEL, MT_DELETE: begin
                if (in_span(p, 11, 8)) sh_held.oref = {sh_held.oref[55:0], b};
                else if (t == MT_CANCEL && in_span(p, 19, 4))
                    sh_held.shares = {sh_held.shares[23:0], b};
            end
            MT_REPLACE: begin
                if (in_span(p, 11, 8)) sh_held.oref = {sh_held.oref[55:0], b};
                else if (in_span(p, 19, 8)) sh_held.sref = {sh_held.sref[55:0], b};
                else if (in_span(p, 27, 4)) sh_held.shares = {sh_held.shares[23:0], b};
                else if (in_span(p, 31, 4)) sh_held.price = {sh_held.price[23:0], b};
            end
            default: ;
        endcase
    endtask

    // Advances the shadow parser by one accepted item and queues any result.
    task automatic parse_item(input t_stream_item it);
        logic [47:0]   off;
        t_frame_result r;
        off = sh_off;
        if (sh_halted) return;
        if (it.eos) begin
            if (sh_ended || sh_phase == PH_LEN_HI) sh_halted = 1'b1;
            else push_error(sh_phase == PH_LEN_LO ? ERR_PREFIX : ERR_PAYLOAD, sh_frame_start);
            return;
        end
        sh_off = sh_off + 48'd1;
        if (sh_ended) begin
            push_error(ERR_AFTER_END, off);
            return;
        end
        if (sh_phase == PH_LEN_LO) begin
            sh_len = {sh_len[7:0], it.b};
            if (sh_len == 16'd0) begin
                sh_ended = 1'b1;
                sh_phase = PH_LEN_HI;
            end else begin
                sh_phase = PH_PAYLOAD;
                sh_pos = '0;
                sh_payload_start = sh_off;
                clear_shadow_fields();
                sh_err = ERR_NONE;
                sh_err_off = '0;
            end
            return;
        end
        if (sh_phase != PH_PAYLOAD) begin
            sh_phase = PH_LEN_LO;
            sh_frame_start = off;
            sh_len = {8'd0, it.b};
            return;
        end
        take_payload(int'(sh_pos), it.b, off);
        sh_pos = sh_pos + 16'd1;
        if (sh_pos < sh_len) return;
        sh_phase = PH_LEN_HI;
        if (sh_err != ERR_NONE) begin
            push_error(sh_err, sh_err_off);
        end else begin
            r = sh_held;
            r.ts = sh_ts48[46:0];
            r.err = ERR_NONE;
            r.eoff = '0;
            frame_results_q.push_back(r);
        end
    endtask

    task automatic add_item(input logic [7:0] b, input logic eos, input logic hold);
        t_stream_item it;
        it.b = b;
        it.eos = eos;
        it.hold = hold;
        stream_q.push_back(it);
    endtask

    // Builds one frame; cut >= 0 ends the stream after that many payload bytes.
    task automatic add_frame(input logic [7:0] t_in, input int fill, input int pick,
                             input int fault, input int cut, input logic hold);
        logic [7:0]  t;
        int          len;
        logic [47:0] ts;
        logic [7:0]  v;
        logic [7:0]  pl [$];
        int          tp [$];
        int          k;
        t = t_in;
        len = frame_len_for(t);
        if (fault == FLT_TYPE) begin
            do t = 8'($urandom_range(0, 255)); while (frame_len_for(t) != 0);
            len = $urandom_range(1, 60);
        end
        if (fault == FLT_LENGTH) len = $urandom_range(0, 1) ? len + 1 : len - 1;
        if (fill == FILL_ZERO) ts = '0;
        else if (fill == FILL_ONES) ts = ONE_DAY - 48'd1;
        else ts = 48'({$urandom, $urandom} % 64'(ONE_DAY));
        if (fault == FLT_TS) ts = $urandom_range(0, 1) ? ONE_DAY : ONE_DAY + 48'($urandom);
        for (int p = 0; p < len; p++) begin
            v = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hFF
                : 8'($urandom_range(0, 255));
            if (p == 0) begin
                v = t;
            end else if (p >= 5 && p <= 10) begin
                v = ts[8 * (10 - p) +: 8];
            end else if (is_text(t, p)) begin
                v = (fill == FILL_ZERO) ? TXT_LO : (fill == FILL_ONES) ? TXT_HI
                    : 8'($urandom_range(TXT_LO, TXT_HI));
                tp.push_back(p);
            end else if (t == MT_SYS && p == 11) begin
                v = EV_CODES[pick < 0 ? $urandom_range(0, 5) : pick];
            end else if ((t == MT_ADD || t == MT_ADD_ATTR || t == MT_TRADE) && p == 19) begin
                v = ((pick < 0) ? $urandom_range(0, 1) : pick) ? SIDE_SELL : SIDE_BUY;
            end else if (t == MT_EXEC_PX && p == 31) begin
                v = ((pick < 0) ? $urandom_range(0, 1) : pick) ? PRN_NO : PRN_YES;
            end
            pl.push_back(v);
        end
        // Content faults land on the field that the caller's type carries.
        case (fault)
            FLT_EVENT: begin
                do v = 8'($urandom_range(0, 255));
                while (v inside {EV_CODES[0], EV_CODES[1], EV_CODES[2],
                                 EV_CODES[3], EV_CODES[4], EV_CODES[5]});
                pl[11] = v;
            end
            FLT_SIDE: begin
                do v = 8'($urandom_range(0, 255)); while (v == SIDE_BUY || v == SIDE_SELL);
                pl[19] = v;
            end
            FLT_PRINT: begin
                do v = 8'($urandom_range(0, 255)); while (v == PRN_YES || v == PRN_NO);
                pl[31] = v;
            end
            FLT_TEXT: begin
                k = tp[$urandom_range(0, tp.size() - 1)];
                pl[k] = $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                        : 8'($urandom_range(127, 255));
            end
            default: ;
        endcase
        add_item(8'(len >> 8), 1'b0, hold);
        add_item(8'(len), 1'b0, 1'b0);
        if (cut >= len) cut = len - 1;
        for (int p = 0; p < len && (cut < 0 || p < cut); p++) add_item(pl[p], 1'b0, 1'b0);
        if (cut >= 0) add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    endtask

    // One stream: clean frames, then a single terminating event, then ignored bytes.
    task automatic build_stream();
        int           fill;
        logic [7:0]   t;
        logic [7:0]   fault_types [$];
        int           scenario;
        logic         first_rand;
        fill = FILL_ZERO;
        first_rand = 1'b1;
        // Directed part: every type, every event, side and printable code, extreme fills.
        for (int e = 0; e < 6; e++) begin
            add_frame(MT_SYS, e % 3, e, FLT_NONE, -1, 1'b0);
        end
        for (int s = 0; s < 2; s++) begin
            add_frame(MT_ADD, s ? FILL_ONES : FILL_ZERO, s, FLT_NONE, -1, 1'b0);
            add_frame(MT_ADD_ATTR, s ? FILL_ZERO : FILL_ONES, s, FLT_NONE, -1, 1'b0);
            add_frame(MT_EXEC_PX, s ? FILL_ONES : FILL_ZERO, s, FLT_NONE, -1, 1'b0);
            add_frame(MT_TRADE, s ? FILL_ZERO : FILL_ONES, s, FLT_NONE, -1, 1'b0);
        end
        // The remaining types; add, attributed add, execute with price and trade are done.
        for (int i = 1; i < 22; i++) begin
            if (TYPE_LIST[i] != MT_ADD && TYPE_LIST[i] != MT_ADD_ATTR
                && TYPE_LIST[i] != MT_EXEC_PX && TYPE_LIST[i] != MT_TRADE)
                add_frame(TYPE_LIST[i], i % 3, -1, FLT_NONE, -1, 1'b0);
        end

        // Random part; the first frame waits until every pending result is back.
        while (stream_q.size() < 1050) begin
            t = $urandom_range(0, 1) ? TYPE_LIST[$urandom_range(0, 9)]
                : TYPE_LIST[$urandom_range(0, 21)];
            fill = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : FILL_RAND;
            add_frame(t, fill, -1, FLT_NONE, -1, first_rand);
            first_rand = 1'b0;
        end

        // The block halts on the first error or end, so the stream ends with one such event.
        scenario = $urandom_range(0, 11);
        case (scenario)
            0: add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            1, 2: begin
                add_item(8'h00, 1'b0, 1'b0);
                add_item(8'h00, 1'b0, 1'b0);
                add_item(8'($urandom_range(0, 255)), scenario == 1, 1'b0);
            end
            3: begin
                add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
            4: add_frame(TYPE_LIST[$urandom_range(0, 21)], FILL_RAND, -1, FLT_NONE,
                         $urandom_range(0, 60), 1'b0);
            5: add_frame(MT_ADD, FILL_RAND, -1, FLT_TYPE, -1, 1'b0);
            6: add_frame(TYPE_LIST[$urandom_range(0, 21)], FILL_RAND, -1, FLT_LENGTH, -1, 1'b0);
            7: add_frame(TYPE_LIST[$urandom_range(0, 21)], FILL_RAND, -1, FLT_TS, -1, 1'b0);
            8: add_frame(MT_SYS, FILL_RAND, -1, FLT_EVENT, -1, 1'b0);
            9: begin
                fault_types = '{MT_ADD, MT_ADD_ATTR, MT_TRADE};
                add_frame(fault_types[$urandom_range(0, 2)], FILL_RAND, -1, FLT_SIDE, -1, 1'b0);
            end
            10: add_frame(MT_EXEC_PX, FILL_RAND, -1, FLT_PRINT, -1, 1'b0);
            default: begin
                fault_types = '{MT_DIR, MT_ADD, MT_ADD_ATTR, MT_TRADE};
                add_frame(fault_types[$urandom_range(0, 3)], FILL_RAND, -1, FLT_TEXT, -1, 1'b0);
            end
        endcase
        repeat ($urandom_range(1, 5))
            add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
    endtask

    // Input driver with random idle bursts.
    t_stream_item in_flight;
    int           send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                parse_item(in_flight);
                if (stream_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 7);
            end
            if (i_valid && !o_ready) begin
                // Hold the current item until it is taken.
            end else if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (stream_q.size() > 0
                         && !(stream_q[0].hold && frame_results_q.size() > 0)) begin
                in_flight = stream_q.pop_front();
                i_valid <= 1'b1;
                i_data_byte <= in_flight.b;
                i_end_of_stream <= in_flight.eos;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    task automatic field_diff(input string nm, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0h, got %0h", nm, want, got);
        end
    endtask

    // Result monitor with random stall bursts.
    int            recv_stall = 0;
    t_frame_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (frame_results_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result, type %0h", o_message_type);
                end else begin
                    want = frame_results_q.pop_front();
                    field_diff("message_type", 64'(want.mtype), 64'(o_message_type));
                    field_diff("stock_locate", 64'(want.locate), 64'(o_stock_locate));
                    field_diff("tracking_number", 64'(want.tracking), 64'(o_tracking_number));
                    field_diff("time_ns", 64'(want.ts), 64'(o_time_ns));
                    field_diff("order_ref", want.oref, o_order_ref);
                    field_diff("second_ref", want.sref, o_second_ref);
                    field_diff("shares", 64'(want.shares), 64'(o_shares));
                    field_diff("price", 64'(want.price), 64'(o_price));
                    field_diff("symbol", want.symbol, o_symbol);
                    field_diff("detail", 64'(want.detail), 64'(o_detail));
                    field_diff("error_code", 64'(want.err), 64'(o_error_code));
                    field_diff("error_offset", 64'(want.eoff), 64'(o_error_offset));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (stream_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
                    recv_stall = $urandom_range(1, 7);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        reset_shadow();
        build_stream();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (stream_q.size() > 0 || i_valid) @(posedge i_clk);
        while (frame_results_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && frame_results_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
